>>> rtl/tcda_pkg.sv
// Shared types and constants for the ten's complement decimal ALU.
`timescale 1ns / 1ps

package tcda_pkg;

  localparam int NIBBLES     = 16;
  localparam int BIN_W       = 32;
  localparam int BCD_DIGITS  = 10;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int DABBLE_BITS = 8;
  localparam int KIND_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 3'd0,
    KIND_NEG   = 3'd1,
    KIND_UCMP  = 3'd2,
    KIND_SCMP  = 3'd3,
    KIND_NZ    = 3'd4,
    KIND_SIGN  = 3'd5,
    KIND_BIN   = 3'd6
  } kind_t;

  typedef logic [1:0] order_t;
  localparam order_t ORD_EQ    = 2'b00;
  localparam order_t ORD_ABOVE = 2'b01;
  localparam order_t ORD_BELOW = 2'b11;

  typedef logic [NIBBLES-1:0][4:0] dsum_t;
  typedef logic [BCD_W-1:0]        bcd_t;

endpackage

>>> rtl/tens_complement_decimal_alu_top.sv
// Ten's complement decimal ALU: four-stage pipeline with stream ports.
// Each item passes the stage 1, 2, 3 and 4 registers before it reaches out_tvalid.
// Throughput: one item per cycle while out_tready is high; the four-stage split of the 32-bit
// binary-to-BCD conversion (8 bits per stage) sets the depth.
// Stalls back-pressure stage by stage; bubbles are filled.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
`timescale 1ns / 1ps

module tens_complement_decimal_alu_top #(
  parameter int DIGITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // operand_a[63:0], operand_b[127:64], binary_value[159:128]
  input  logic [2:0]   in_tuser,   // kind[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // result_digits[63:0], order[65:64], flag[66], zero[71:67]
);

  localparam int          DW        = 4 * DIGITS;
  localparam int          SIGN_LSB  = 4 * (DIGITS - 1);
  localparam logic [64:0] MASK_W    = (65'd1 << DW) - 65'd1;
  localparam logic [63:0] DIG_MASK  = MASK_W[63:0];
  localparam int          NB        = tcda_pkg::NIBBLES;
  localparam int          DB        = tcda_pkg::DABBLE_BITS;

  // handshake
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: operand prep, digit sums, compares, tests, dabble 31..24
  tcda_pkg::kind_t  kind_in;
  logic [63:0]      a_m, b_m, opa, opb;
  logic [31:0]      bin_in;
  logic             na, nb, cin_nxt;
  tcda_pkg::order_t ord_nxt;
  logic             flag_nxt;
  tcda_pkg::dsum_t  t_nxt;
  tcda_pkg::bcd_t   bcd1_nxt;

  assign kind_in = tcda_pkg::kind_t'(in_tuser);
  assign a_m     = in_tdata[63:0] & DIG_MASK;
  assign b_m     = in_tdata[127:64] & DIG_MASK;
  assign bin_in  = in_tdata[159:128];
  assign na      = a_m[SIGN_LSB +: 4] >= 4'd5;
  assign nb      = b_m[SIGN_LSB +: 4] >= 4'd5;

  always_comb begin
    opa     = a_m;
    opb     = b_m;
    cin_nxt = 1'b0;
    if (kind_in == tcda_pkg::KIND_NEG) begin
      for (int i = 0; i < NB; i++) begin
        opa[4*i +: 4] = 4'd9 - a_m[4*i +: 4];
      end
      opb     = '0;
      cin_nxt = 1'b1;
    end
    for (int i = 0; i < NB; i++) begin
      t_nxt[i] = {1'b0, opa[4*i +: 4]} + {1'b0, opb[4*i +: 4]};
    end
  end

  always_comb begin
    ord_nxt  = tcda_pkg::ORD_EQ;
    flag_nxt = 1'b0;
    unique case (kind_in)
      tcda_pkg::KIND_UCMP: begin
        if (a_m > b_m)      ord_nxt = tcda_pkg::ORD_ABOVE;
        else if (a_m < b_m) ord_nxt = tcda_pkg::ORD_BELOW;
      end
      tcda_pkg::KIND_SCMP: begin
        if (na && !nb)      ord_nxt = tcda_pkg::ORD_BELOW;
        else if (!na && nb) ord_nxt = tcda_pkg::ORD_ABOVE;
        else if (a_m > b_m) ord_nxt = tcda_pkg::ORD_ABOVE;
        else if (a_m < b_m) ord_nxt = tcda_pkg::ORD_BELOW;
      end
      tcda_pkg::KIND_NZ:   flag_nxt = |a_m;
      tcda_pkg::KIND_SIGN: flag_nxt = na;
      default: ;
    endcase
  end

  tcda_dabble u_dab1 (
    .bcd_in  ('0),
    .bits_in (bin_in[31:24]),
    .bcd_out (bcd1_nxt)
  );

  tcda_pkg::kind_t  kind1_r, kind2_r, kind3_r;
  tcda_pkg::dsum_t  t1_r, t2_r;
  logic             cin1_r;
  tcda_pkg::order_t ord1_r, ord2_r, ord3_r;
  logic             flag1_r, flag2_r, flag3_r;
  tcda_pkg::bcd_t   bcd1_r, bcd2_r, bcd3_r;
  logic [23:0]      bin1_r;
  logic [15:0]      bin2_r;
  logic [DB-1:0]    bin3_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1_r <= kind_in;
      t1_r    <= t_nxt;
      cin1_r  <= cin_nxt;
      ord1_r  <= ord_nxt;
      flag1_r <= flag_nxt;
      bcd1_r  <= bcd1_nxt;
      bin1_r  <= bin_in[23:0];
    end
  end

  // stage 2: decimal carry lookahead, dabble 23..16
  logic [4:0][NB-1:0] gk, pk;
  logic [NB-1:0]      c_nxt;
  tcda_pkg::bcd_t     bcd2_nxt;
  logic [NB-1:0]      c2_r;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      gk[0][i] = t1_r[i] >= 5'd10;
      pk[0][i] = t1_r[i] == 5'd9;
    end
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < NB; i++) begin
        if (i >= (1 << l)) begin
          gk[l+1][i] = gk[l][i] | (pk[l][i] & gk[l][i - (1 << l)]);
          pk[l+1][i] = pk[l][i] & pk[l][i - (1 << l)];
        end else begin
          gk[l+1][i] = gk[l][i];
          pk[l+1][i] = pk[l][i];
        end
      end
    end
    c_nxt[0] = cin1_r;
    for (int i = 1; i < NB; i++) begin
      c_nxt[i] = gk[4][i-1] | (pk[4][i-1] & cin1_r);
    end
  end

  tcda_dabble u_dab2 (
    .bcd_in  (bcd1_r),
    .bits_in (bin1_r[23:16]),
    .bcd_out (bcd2_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      kind2_r <= kind1_r;
      t2_r    <= t1_r;
      c2_r    <= c_nxt;
      ord2_r  <= ord1_r;
      flag2_r <= flag1_r;
      bcd2_r  <= bcd2_nxt;
      bin2_r  <= bin1_r[15:0];
    end
  end

  // stage 3: sum digits, dabble 15..8
  logic [63:0]    sum_nxt, sum3_r;
  logic [4:0]     s5;
  tcda_pkg::bcd_t bcd3_nxt;

  always_comb begin
    sum_nxt = '0;
    s5      = '0;
    for (int i = 0; i < NB; i++) begin
      s5 = t2_r[i] + {4'd0, c2_r[i]};
      if (s5 > 5'd9) s5 = s5 - 5'd10;
      sum_nxt[4*i +: 4] = s5[3:0];
    end
  end

  tcda_dabble u_dab3 (
    .bcd_in  (bcd2_r),
    .bits_in (bin2_r[15:8]),
    .bcd_out (bcd3_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy3) begin
      kind3_r <= kind2_r;
      sum3_r  <= sum_nxt;
      ord3_r  <= ord2_r;
      flag3_r <= flag2_r;
      bcd3_r  <= bcd3_nxt;
      bin3_r  <= bin2_r[7:0];
    end
  end

  // stage 4: dabble 7..0, result select, output register
  tcda_pkg::bcd_t   bcd4_nxt;
  logic [63:0]      res_nxt, res4_r;
  tcda_pkg::order_t ord4_r;
  logic             flag4_r;

  tcda_dabble u_dab4 (
    .bcd_in  (bcd3_r),
    .bits_in (bin3_r),
    .bcd_out (bcd4_nxt)
  );

  always_comb begin
    unique case (kind3_r)
      tcda_pkg::KIND_ADD,
      tcda_pkg::KIND_NEG: res_nxt = sum3_r & DIG_MASK;
      tcda_pkg::KIND_BIN: res_nxt = {{(64 - tcda_pkg::BCD_W){1'b0}}, bcd4_nxt} & DIG_MASK;
      default:            res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      res4_r  <= res_nxt;
      ord4_r  <= ord3_r;
      flag4_r <= flag3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {5'd0, flag4_r, ord4_r, res4_r};

endmodule

>>> rtl/tcda_dabble.sv
// Eight shift-and-add-3 steps of binary to BCD conversion.
`timescale 1ns / 1ps

module tcda_dabble (
  input  tcda_pkg::bcd_t                        bcd_in,
  input  logic [tcda_pkg::DABBLE_BITS-1:0]      bits_in,
  output tcda_pkg::bcd_t                        bcd_out
);

  tcda_pkg::bcd_t step [tcda_pkg::DABBLE_BITS+1];
  tcda_pkg::bcd_t adj  [tcda_pkg::DABBLE_BITS];

  always_comb begin
    step[0] = bcd_in;
    for (int s = 0; s < tcda_pkg::DABBLE_BITS; s++) begin
      adj[s] = step[s];
      for (int d = 0; d < tcda_pkg::BCD_DIGITS; d++) begin
        if (step[s][4*d +: 4] >= 4'd5) begin
          adj[s][4*d +: 4] = step[s][4*d +: 4] + 4'd3;
        end
      end
      // msb first
      step[s+1] = {adj[s][tcda_pkg::BCD_W-2:0], bits_in[tcda_pkg::DABBLE_BITS-1-s]};
    end
    bcd_out = step[tcda_pkg::DABBLE_BITS];
  end

endmodule

>>> tb/decimal_alu_checker.sv
// Result checker for the decimal ALU: predicts each operation and compares output transfers.
`timescale 1ns / 1ps

module decimal_alu_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,   // operand_a[63:0], operand_b[127:64], binary_value[159:128]
  input  logic [2:0]   in_tuser,   // kind[2:0]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [71:0]  out_tdata,  // result_digits[63:0], order[65:64], flag[66], zero[71:67]
  output int           fail_count,
  output int           outstanding
);

  localparam int DIGITS = tcda_pkg::NIBBLES;

  typedef struct packed {
    logic [4:0]       pad;
    logic             flag;
    tcda_pkg::order_t order;
    logic [63:0]      digits;
  } alu_result_t;

  alu_result_t expected_results[$];
  alu_result_t got;
  alu_result_t want;
  int          n_fail = 0;

  function automatic logic [63:0] bcd_sum(logic [63:0] a, logic [63:0] b, logic cin);
    logic [63:0] r;
    logic [4:0]  s;
    logic        c;
    r = '0;
    c = cin;
    for (int i = 0; i < DIGITS; i++) begin
      s = 5'(a[4*i +: 4]) + 5'(b[4*i +: 4]) + 5'(c);
      if (s > 5'd9) begin
        s = s - 5'd10;
        c = 1'b1;
      end else begin
        c = 1'b0;
      end
      r[4*i +: 4] = s[3:0];
    end
    return r;
  endfunction

  function automatic tcda_pkg::order_t bcd_order(logic [63:0] a, logic [63:0] b);
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (a[4*i +: 4] > b[4*i +: 4]) return tcda_pkg::ORD_ABOVE;
      if (a[4*i +: 4] < b[4*i +: 4]) return tcda_pkg::ORD_BELOW;
    end
    return tcda_pkg::ORD_EQ;
  endfunction

  function automatic logic is_negative(logic [63:0] a);
    return a[4*(DIGITS-1) +: 4] >= 4'd5;
  endfunction

  function automatic alu_result_t predict_result(logic [2:0] kind, logic [63:0] a,
                                                 logic [63:0] b, logic [31:0] bin);
    alu_result_t r;
    logic [63:0] nines;
    logic [31:0] v;
    logic        na;
    logic        nb;
    r = '0;
    case (kind)
      tcda_pkg::KIND_ADD: r.digits = bcd_sum(a, b, 1'b0);
      tcda_pkg::KIND_NEG: begin
        nines = '0;
        for (int i = 0; i < DIGITS; i++) nines[4*i +: 4] = 4'd9 - a[4*i +: 4];
        r.digits = bcd_sum(nines, '0, 1'b1);
      end
      tcda_pkg::KIND_UCMP: r.order = bcd_order(a, b);
      tcda_pkg::KIND_SCMP: begin
        na = is_negative(a);
        nb = is_negative(b);
        if (na && !nb) r.order = tcda_pkg::ORD_BELOW;
        else if (!na && nb) r.order = tcda_pkg::ORD_ABOVE;
        else r.order = bcd_order(a, b);
      end
      tcda_pkg::KIND_NZ:   r.flag = |a[4*DIGITS-1:0];
      tcda_pkg::KIND_SIGN: r.flag = is_negative(a);
      tcda_pkg::KIND_BIN: begin
        v = bin;
        for (int i = 0; i < DIGITS; i++) begin
          r.digits[4*i +: 4] = 4'(v % 10);
          v = v / 10;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] exp_val, logic [63:0] act_val);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
    n_fail++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // pop before push so a result can never match the item accepted on the same edge
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing pending, actual %h", $time, got);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          if (got.digits !== want.digits) note_mismatch("result_digits", want.digits, got.digits);
          if (got.order !== want.order)
            note_mismatch("order", 64'(want.order), 64'(got.order));
          if (got.flag !== want.flag)
            note_mismatch("flag", 64'(want.flag), 64'(got.flag));
          if (got.pad !== want.pad)
            note_mismatch("padding", 64'(want.pad), 64'(got.pad));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_result(in_tuser, in_tdata[63:0],
                                                  in_tdata[127:64], in_tdata[159:128]));
    end
    fail_count  <= n_fail;
    outstanding <= expected_results.size();
  end

endmodule

>>> tb/testbench.sv
// Testbench top for the decimal ALU: clock, reset, stream stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int         RESET_CYCLES = 10;
  localparam int         RANDOM_ITEMS = 1850;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         DRAIN_CYCLES = 20;
  localparam logic [2:0] KIND_UNUSED  = 3'd7;
  localparam logic [63:0] ALL_NINES   = 64'h9999_9999_9999_9999;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int         NIBBLES      = tcda_pkg::NIBBLES;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;   // operand_a[63:0], operand_b[127:64], binary_value[159:128]
  logic [2:0]   in_tuser;   // kind[2:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;  // result_digits[63:0], order[65:64], flag[66], zero[71:67]
  int           fail_count;
  int           outstanding;
  int           cycle_count = 0;
  bit           sender_quiet = 1'b0;
  bit           receiver_quiet = 1'b0;

  tens_complement_decimal_alu_top #(.DIGITS(16)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  decimal_alu_checker alu_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none at all while quiet
  function automatic int idle_cycles(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    int          len;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4:
        for (int i = 0; i < NIBBLES; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
      6: begin
        v   = '0;
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
      end
      7:
        for (int i = 0; i < NIBBLES; i++)
          v[4*i +: 4] = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'd9;
      8: begin
        for (int i = 0; i < NIBBLES; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
        v[4*(NIBBLES-1) +: 4] = 4'($urandom_range(4, 5));
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pick_partner(logic [63:0] a);
    logic [63:0] v;
    int          pos;
    case ($urandom_range(0, 3))
      2: v = a;
      3: begin
        v   = a;
        pos = $urandom_range(0, NIBBLES - 1);
        v[4*pos +: 4] = 4'($urandom_range(0, 15));
      end
      default: v = pick_operand();
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_binary();
    logic [31:0] p;
    case ($urandom_range(0, 5))
      4: return 32'($urandom_range(0, 999));
      5: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(logic [2:0] kind, logic [63:0] a, logic [63:0] b, logic [31:0] bin);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {bin, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = idle_cycles(sender_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int ready_run;
    int stall;
    out_tready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      ready_run = $urandom_range(1, 30);
      repeat (ready_run) @(posedge clk);
      if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
      stall = idle_cycles(receiver_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    logic [2:0]  kind;
    logic [63:0] a;
    logic [63:0] b;
    int          sel;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = tcda_pkg::KIND_ADD;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // adder: zero, wraparound, carry chain, digits above nine; negate; unsigned compare
    send_op(tcda_pkg::KIND_ADD, '0, '0, '0);
    send_op(tcda_pkg::KIND_ADD, ALL_NINES, 64'h1, '0);
    send_op(tcda_pkg::KIND_ADD, ALL_NINES, ALL_NINES, '0);
    send_op(tcda_pkg::KIND_ADD, ALL_ONES, ALL_ONES, '0);
    send_op(tcda_pkg::KIND_NEG, '0, '0, '0);
    send_op(tcda_pkg::KIND_NEG, ALL_NINES, '0, '0);
    send_op(tcda_pkg::KIND_NEG, ALL_ONES, '0, '0);
    send_op(tcda_pkg::KIND_NEG, 64'h5000_0000_0000_0000, '0, '0);
    send_op(tcda_pkg::KIND_UCMP, 64'h1234_5678_9012_3456, 64'h1234_5678_9012_3456, '0);
    send_op(tcda_pkg::KIND_UCMP, 64'h1000_0000_0000_0000, 64'h2000_0000_0000_0000, '0);
    send_op(tcda_pkg::KIND_UCMP, 64'h1, 64'h0, '0);
    // signed compare: each sign pairing; nonzero and sign tests, binary conversion, unused kind
    send_op(tcda_pkg::KIND_SCMP, 64'h5000_0000_0000_0000, 64'h4999_9999_9999_9999, '0);
    send_op(tcda_pkg::KIND_SCMP, '0, ALL_NINES, '0);
    send_op(tcda_pkg::KIND_SCMP, ALL_NINES, 64'h5000_0000_0000_0000, '0);
    send_op(tcda_pkg::KIND_SCMP, 64'h42, 64'h42, '0);
    send_op(tcda_pkg::KIND_NZ, '0, ALL_ONES, '0);
    send_op(tcda_pkg::KIND_NZ, 64'h1000_0000_0000_0000, '0, '0);
    send_op(tcda_pkg::KIND_SIGN, 64'h4999_9999_9999_9999, '0, '0);
    send_op(tcda_pkg::KIND_SIGN, 64'h5000_0000_0000_0000, '0, '0);
    send_op(tcda_pkg::KIND_SIGN, 64'hF000_0000_0000_0000, '0, '0);
    send_op(tcda_pkg::KIND_BIN, '0, '0, '0);
    send_op(tcda_pkg::KIND_BIN, '0, '0, 32'hFFFF_FFFF);
    send_op(tcda_pkg::KIND_BIN, '0, '0, 32'd1000000000);
    send_op(KIND_UNUSED, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF);
    wait_for_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel  = $urandom_range(0, 20);
      kind = (sel == 20) ? KIND_UNUSED : 3'(sel % 7);
      a    = pick_operand();
      b    = pick_partner(a);
      if ($urandom_range(0, 49) == 0) sender_quiet = !sender_quiet;
      send_op(kind, a, b, pick_binary());
      if (n == RANDOM_ITEMS / 2) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      if (outstanding != 0) $display("%0d results never arrived", outstanding);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
